[hdl/cse_pkg.sv]
// cse_pkg: shared constants and the sequencer state type of the counting sort engine
// no dependencies
package cse_pkg;

	localparam int KEY_W = 8;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_DRAIN = 4'b0010,
		ST_READ  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

endpackage

[hdl/cse_hist.sv]
// cse_hist: histogram memory with one write and one registered read port
// per-bin valid flops give zero for bins not written since the last clear
// uses cse_pkg
module cse_hist #(
	parameter int BIN_BITS = cse_pkg::KEY_W,
	parameter int CNT_W    = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  logic                rd_en,
	input  logic [BIN_BITS-1:0] rd_addr,
	output logic [CNT_W-1:0]    rd_data,
	input  logic                wr_en,
	input  logic [BIN_BITS-1:0] wr_addr,
	input  logic [CNT_W-1:0]    wr_data
);

	localparam int BINS = 1 << BIN_BITS;

	logic [CNT_W-1:0] mem_q [BINS];
	logic [BINS-1:0]  vld_q;
	logic [CNT_W-1:0] rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

[hdl/counting_sort_engine_unit.sv]
// counting_sort_engine_unit: top level, key loading, histogram scan and result output
// uses cse_pkg and cse_hist
//
// Keys are taken one per cycle while loading: each key is masked to min(KEY_BITS, KEY_W) bits,
// saturated to key_max and counted by a read-modify-write of the histogram,
// with the count forwarded when the same bin is hit in back-to-back cycles.
// Keys beyond MAX_ITEMS are dropped and flag overflow on the run. The key
// marked last is followed by a drain state, then a single counter and compare
// walks the bins in ascending order: each bin is read in ST_READ, then ST_EMIT
// gives one result for each key counted in it, holding while the output
// stalls, and the walk stops at the bin that holds the final key. No request
// is taken during the scan. The histogram is cleared at once through per-bin
// valid flops, so there is no clearing pass.
module counting_sort_engine_unit #(
	parameter int MAX_ITEMS = 64,
	parameter int KEY_BITS  = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [cse_pkg::KEY_W-1:0] cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [cse_pkg::KEY_W-1:0] key,
	input  logic                     last_key,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [cse_pkg::KEY_W-1:0] sorted_key,
	output logic                     last_out,
	output logic                     overflow
);

	localparam int KW       = cse_pkg::KEY_W;
	localparam int BIN_BITS = (KEY_BITS < KW) ? KEY_BITS : KW;
	localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
	localparam logic [KW-1:0] KEY_MASK = KW'((1 << BIN_BITS) - 1);

	cse_pkg::state_t state_q;

	logic [KW-1:0]       key_max_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                ovf_q;
	logic [BIN_BITS-1:0] bin_q;
	logic [CNT_W-1:0]    rep_q;
	logic [CNT_W-1:0]    emit_q;

	logic                s1_v_s1;
	logic [BIN_BITS-1:0] idx_s1;
	logic                fwd_s1;
	logic [CNT_W-1:0]    fval_s1;

	logic                out_valid_q;
	logic [KW-1:0]       sorted_key_q;
	logic                last_out_q;
	logic                overflow_q;

	logic                acc;
	logic                count_it;
	logic [KW-1:0]       masked;
	logic [KW-1:0]       sat;
	logic [BIN_BITS-1:0] idx;
	logic [CNT_W-1:0]    base;
	logic [CNT_W-1:0]    inc;
	logic [CNT_W-1:0]    emit_nxt;
	logic                slot_free;
	logic                bin_done;
	logic                load_out;
	logic                finish;
	logic                rd_en;
	logic [BIN_BITS-1:0] rd_addr;
	logic [CNT_W-1:0]    rd_data;

	// key loading
	assign in_stall = (state_q != cse_pkg::ST_LOAD);
	assign acc      = in_valid && !in_stall;
	assign count_it = acc && (cnt_q < CNT_W'(MAX_ITEMS));
	assign masked   = key & KEY_MASK;
	assign sat      = (masked > key_max_q) ? key_max_q : masked;
	assign idx      = sat[BIN_BITS-1:0];

	assign base = fwd_s1 ? fval_s1 : rd_data;
	assign inc  = base + CNT_W'(1);

	// scan and output
	assign emit_nxt  = emit_q + CNT_W'(1);
	assign slot_free = !out_valid_q || !out_stall;
	assign bin_done  = (rep_q == rd_data);
	assign load_out  = (state_q == cse_pkg::ST_EMIT) && !bin_done && slot_free;
	assign finish    = load_out && (emit_nxt == cnt_q);

	assign rd_en   = count_it || (state_q == cse_pkg::ST_READ);
	assign rd_addr = (state_q == cse_pkg::ST_READ) ? bin_q : idx;

	cse_hist #(
		.BIN_BITS(BIN_BITS),
		.CNT_W   (CNT_W)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (finish),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (s1_v_s1),
		.wr_addr(idx_s1),
		.wr_data(inc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_max_q <= KW'(10);
		end else if (cfg_we) begin
			key_max_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end else begin
			s1_v_s1 <= count_it;
			fwd_s1  <= count_it && s1_v_s1 && (idx_s1 == idx);
		end
	end

	always_ff @(posedge clk) begin
		if (count_it) begin
			idx_s1  <= idx;
			fval_s1 <= inc;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cse_pkg::ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			bin_q   <= '0;
			rep_q   <= '0;
			emit_q  <= '0;
		end else begin
			case (state_q)
				cse_pkg::ST_LOAD: begin
					if (count_it) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (acc) begin
						ovf_q <= 1'b1;
					end
					if (acc && last_key) begin
						state_q <= cse_pkg::ST_DRAIN;
					end
				end
				cse_pkg::ST_DRAIN: begin
					bin_q   <= '0;
					emit_q  <= '0;
					state_q <= cse_pkg::ST_READ;
				end
				cse_pkg::ST_READ: begin
					rep_q   <= '0;
					state_q <= cse_pkg::ST_EMIT;
				end
				cse_pkg::ST_EMIT: begin
					if (bin_done) begin
						bin_q   <= bin_q + BIN_BITS'(1);
						state_q <= cse_pkg::ST_READ;
					end else if (load_out) begin
						rep_q  <= rep_q + CNT_W'(1);
						emit_q <= emit_nxt;
						if (finish) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= cse_pkg::ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= cse_pkg::ST_LOAD;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			sorted_key_q <= KW'(bin_q);
			last_out_q   <= (emit_nxt == cnt_q);
			overflow_q   <= ovf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sorted_key = sorted_key_q;
	assign last_out   = last_out_q;
	assign overflow   = overflow_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ITEMS))
		else $error("key count above capacity");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == cse_pkg::ST_EMIT))
		else $error("result produced outside the scan");

	a_wr_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_s1 |-> (state_q == cse_pkg::ST_LOAD || state_q == cse_pkg::ST_DRAIN))
		else $error("histogram update during the scan");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (emit_q < cnt_q))
		else $error("more results than loaded keys");

endmodule
